### hw/rtl/rrc_pkg.sv
// Shared types and constants of the range request coalescer.
package rrc_pkg;

	localparam int unsigned DEF_ENTRIES = 16;
	localparam int unsigned MAX_RESULTS = 16;
	localparam logic [30:0] BUDGET_RESET = 31'd65536;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_PERM = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_NONCE  = 2'd0,
		REG_FSIZE  = 2'd1,
		REG_BUDGET = 2'd2
	} reg_idx_t;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] nonce;
		logic [31:0] first_pos;
		logic [31:0] end_pos;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        range_valid;
		logic [31:0] range_start;
		logic [30:0] range_length;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;

endpackage

### hw/rtl/rrc_if.sv
// Valid/ready channel interface carrying one payload word.
interface rrc_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/range_request_coalescer.sv
// Range request coalescer: sorted range list with merge on add and budgeted dispatch on tick.
//
// An add word is checked; if it passes, the sequencer walks the stored ranges while searching
// and merging, then moves the tail entries, shifting them up for an insert or packing them
// down after a merge, and then gives its result. A tick, for each dispatched range, sizes it,
// shifts the list down by one entry (a split instead trims the front range and ends the tick),
// gives the result and resumes; at most 16 ranges are dispatched per tick. Searching uses the
// shared compare unit, and the list shifter moves one entry per cycle. One word is handled at
// a time; the input side is ready again once the last result of the word is taken.
module range_request_coalescer import rrc_pkg::*; #(
	parameter int unsigned ENTRIES = DEF_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	rrc_if.sink   req,
	rrc_if.source rsp,
	rrc_if.sink   cfg
);
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b0_0000_0001,
		S_FIND  = 9'b0_0000_0010,
		S_MERGE = 9'b0_0000_0100,
		S_SHIFT = 9'b0_0000_1000,
		S_TICK  = 9'b0_0001_0000,
		S_POP   = 9'b0_0010_0000,
		S_OUT   = 9'b0_0100_0000,
		S_WAIT  = 9'b0_1000_0000,
		S_PACK  = 9'b1_0000_0000
	} state_t;

	state_t      state_q;
	logic [31:0] nonce_q, fsize_q;
	logic [30:0] budget_q, left_q;
	logic [31:0] mem_s [ENTRIES];
	logic [31:0] mem_e [ENTRIES];
	logic [CW-1:0] count_q, i_q, j_q, p_q;
	logic [31:0] s_q, e_q;
	logic [4:0]  k_q;
	rsp_t        out_q;
	logic        out_v_q;
	logic        after_q;   // state after the result is taken: 1 = continue tick

	// one entry read port addressed by the sequencer
	logic [CW-1:0] ra;
	logic [31:0]   rd_s, rd_e;
	always_comb begin
		case (state_q)
			S_FIND:  ra = i_q;
			S_MERGE: ra = j_q;
			S_PACK:  ra = j_q;
			default: ra = '0;
		endcase
	end
	assign rd_s = mem_s[ra[IW-1:0]];
	assign rd_e = mem_e[ra[IW-1:0]];

	// shared compare unit
	logic [31:0] cmp_a, cmp_b;
	logic        cmp_lt;
	always_comb begin
		case (state_q)
			S_FIND:  begin cmp_a = rd_e; cmp_b = s_q; end
			S_MERGE: begin cmp_a = e_q;  cmp_b = rd_s; end
			default: begin cmp_a = '0;   cmp_b = '0; end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	// front range length for tick
	logic [31:0] flen;
	assign flen = mem_e[0] - mem_s[0];
	logic split;
	assign split = flen > {1'b0, left_q};

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	logic bad, real_e_gt;
	logic [31:0] real_e;
	assign bad = req.data.first_pos > fsize_q || req.data.end_pos > fsize_q ||
		(req.data.end_pos != '0 && req.data.end_pos <= req.data.first_pos);
	assign real_e = (req.data.end_pos == '0) ? fsize_q : req.data.end_pos;
	assign real_e_gt = real_e > req.data.first_pos;

	// status of the incoming word before any list work
	status_t add_st;
	always_comb begin
		if (req.data.kind == KIND_TICK) add_st = ST_OK;
		else if (bad) add_st = ST_INVALID;
		else if (req.data.nonce != nonce_q) add_st = ST_NO_PERM;
		else add_st = ST_OK;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_q  <= '0;
			fsize_q  <= '0;
			budget_q <= BUDGET_RESET;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.data.index))
				REG_NONCE:  nonce_q  <= cfg.data.data;
				REG_FSIZE:  fsize_q  <= cfg.data.data;
				REG_BUDGET: budget_q <= cfg.data.data[30:0];
				default: ;
			endcase
		end
	end

	// list storage: shift tail, write merged range, pack tail, pop, split
	always_ff @(posedge clk) begin
		case (state_q)
			S_SHIFT: begin
				if (p_q != '0) begin
					mem_s[p_q[IW-1:0]] <= (p_q > i_q) ? mem_s[IW'(p_q - 1'b1)] : s_q;
					mem_e[p_q[IW-1:0]] <= (p_q > i_q) ? mem_e[IW'(p_q - 1'b1)] : e_q;
				end else begin
					mem_s[0] <= s_q;
					mem_e[0] <= e_q;
				end
			end
			S_PACK: begin
				if (p_q == i_q) begin
					mem_s[p_q[IW-1:0]] <= s_q;
					mem_e[p_q[IW-1:0]] <= e_q;
				end else if (j_q < count_q) begin
					mem_s[p_q[IW-1:0]] <= rd_s;
					mem_e[p_q[IW-1:0]] <= rd_e;
				end
			end
			S_POP: begin
				if (k_q == '1) begin
					mem_s[0] <= mem_s[0] + {1'b0, left_q};
				end else if (p_q + 1'b1 < count_q) begin
					mem_s[p_q[IW-1:0]] <= mem_s[IW'(p_q + 1'b1)];
					mem_e[p_q[IW-1:0]] <= mem_e[IW'(p_q + 1'b1)];
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
			after_q <= 1'b0;
			i_q <= '0; j_q <= '0; p_q <= '0; k_q <= '0;
			left_q <= '0; s_q <= '0; e_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						out_q <= '{status: add_st, range_valid: 1'b0, range_start: '0,
							range_length: '0, last: 1'b1};
						if (req.data.kind == KIND_TICK) begin
							left_q  <= budget_q;
							k_q     <= '0;
							state_q <= S_TICK;
						end else if (add_st != ST_OK || !real_e_gt) begin
							out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
						end else begin
							s_q <= req.data.first_pos;
							e_q <= real_e;
							i_q <= '0;
							state_q <= S_FIND;
						end
					end
				end
				// walk past ranges ending before s
				S_FIND: begin
					if (i_q < count_q && cmp_lt) i_q <= i_q + 1'b1;
					else begin
						j_q <= i_q;
						state_q <= S_MERGE;
					end
				end
				// absorb ranges starting at or before e
				S_MERGE: begin
					if (j_q < count_q && !cmp_lt) begin
						if (rd_s < s_q) s_q <= rd_s;
						if (rd_e > e_q) e_q <= rd_e;
						j_q <= j_q + 1'b1;
					end else if (j_q == i_q && count_q >= CW'(ENTRIES)) begin
						out_q.status <= ST_FULL;
						out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
					end else if (j_q == i_q) begin
						// insert: shift tail up one, from the top down
						p_q <= count_q;
						count_q <= count_q + 1'b1;
						state_q <= S_SHIFT;
					end else begin
						// write merged range at i, then move tail from j down behind it
						p_q <= i_q;
						state_q <= S_PACK;
					end
				end
				S_SHIFT: begin
					if (p_q == i_q) begin
						out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
					end else p_q <= p_q - 1'b1;
				end
				S_PACK: begin
					if (p_q == i_q) p_q <= p_q + 1'b1;
					else if (j_q < count_q) begin
						p_q <= p_q + 1'b1;
						j_q <= j_q + 1'b1;
					end else begin
						count_q <= p_q;
						out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
					end
				end
				S_TICK: begin
					if (left_q == '0 || count_q == '0 || k_q == 5'(MAX_RESULTS)) begin
						if (k_q == '0) begin
							out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
						end else state_q <= S_IDLE;
					end else begin
						out_q.range_valid <= 1'b1;
						out_q.range_start <= mem_s[0];
						out_q.last <= 1'b0;
						if (split) begin
							out_q.range_length <= left_q;
							k_q <= '1;
						end else begin
							out_q.range_length <= flen[30:0];
							left_q <= left_q - flen[30:0];
							k_q <= k_q + 1'b1;
						end
						p_q <= '0;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (k_q == '1) begin
						out_q.last <= 1'b1;
						out_v_q <= 1'b1; after_q <= 1'b0; state_q <= S_WAIT;
					end else if (p_q + 1'b1 < count_q) p_q <= p_q + 1'b1;
					else begin
						count_q <= count_q - 1'b1;
						out_q.last <= (left_q == '0) || (count_q == CW'(1)) ||
							(k_q == 5'(MAX_RESULTS));
						out_v_q <= 1'b1; after_q <= 1'b1; state_q <= S_WAIT;
					end
				end
				S_OUT: state_q <= S_TICK;
				// hold the result word until taken
				S_WAIT: begin
					if (rsp.ready) begin
						out_v_q <= 1'b0;
						state_q <= (after_q && !out_q.last) ? S_OUT : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES)) else $error("range count overflow");
	a_out_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> state_q == S_WAIT) else $error("result outside wait");
	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready) else $error("ready while busy");
endmodule
